[hw/rtl/assert_macros.svh]
// assertion macros shared by the rtl of the run quality encoder
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising edge of clk, off while rst_n is low
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same check, also active during reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hw/rtl/drqe_pkg.sv]
// types and constants of the dominant run quality encoder
// no dependencies; used by drqe_ram users and the top level
package drqe_pkg;

  localparam int MaxClasses  = 128;
  localparam int QualSymbols = 95;
  localparam int TableDepth  = MaxClasses * QualSymbols;
  localparam int TableAw     = $clog2(TableDepth);
  localparam int RankW       = 7;

  localparam logic [6:0] FirstQual  = 7'd32;
  localparam logic [7:0] RunLimit   = 8'd254;
  localparam logic [7:0] RunCont    = 8'd255;
  localparam logic [7:0] DiverseTag = 8'd255;

  // configuration port
  localparam int          CfgAw        = 2;
  localparam int          CfgDw        = 32;
  localparam logic [1:0]  CfgAddrMarker = 2'd0;
  localparam logic [6:0]  MarkerReset  = 7'd1;

  typedef enum logic [1:0] {
    OP_QUAL  = 2'd0,
    OP_LINE  = 2'd1,
    OP_TABLE = 2'd2,
    OP_FLUSH = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t    opcode;
    logic [6:0] quality;
    logic [6:0] dom_index;
    logic       diverse_line;
    logic [6:0] rank_value;
  } in_beat_t;

  typedef struct packed {
    logic       run_valid;
    logic [7:0] run_byte;
    logic       marker_valid;
    logic       symbol_valid;
    logic [6:0] symbol;
    logic       tag_valid;
    logic [7:0] line_tag;
    logic       diverse_valid;
    logic [6:0] diverse_byte;
  } out_beat_t;

endpackage

[hw/rtl/drqe_ram.sv]
// generic simple dual port ram, one write and one registered read port
// no dependencies
module drqe_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/dominant_run_quality_encoder.sv]
// Dominant run quality encoder. Takes one beat per cycle unless stalled: quality bytes,
// line starts, rank table writes and a final flush, and gives at most one result beat per
// input beat. The rank table (128 classes x 95 columns, 7-bit ranks) sits in one ram with
// a registered read: a beat's table access is issued in the cycle it is accepted and the
// run counter is updated when the beat leaves the first stage register, and a new beat is
// accepted every cycle while out_ready stays high.
// Table entries are undefined until written, so no clearing pass follows reset.
// Depends on drqe_pkg, drqe_ram and assert_macros.svh.
`include "assert_macros.svh"

module dominant_run_quality_encoder (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  drqe_pkg::in_beat_t        in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output drqe_pkg::out_beat_t       out_data,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [drqe_pkg::CfgAw-1:0] cfg_paddr,
  input  logic [drqe_pkg::CfgDw-1:0] cfg_pwdata,
  output logic [drqe_pkg::CfgDw-1:0] cfg_prdata,
  output logic                      cfg_pready
);

  typedef enum logic [1:0] {
    K_RANK,
    K_DIV,
    K_TAG,
    K_FLUSH
  } kind_t;

  logic [6:0]                    marker_r;
  logic [6:0]                    cur_class_r;
  logic                          cur_div_r;
  logic [7:0]                    run_cnt_r;
  logic [7:0]                    run_cnt_nxt;
  logic                          s1_valid_r;
  kind_t                         s1_kind_r;
  logic [6:0]                    s1_byte_r;
  logic [7:0]                    s1_tag_r;
  logic                          out_valid_r;
  drqe_pkg::out_beat_t           out_r;
  drqe_pkg::out_beat_t           res;
  logic                          has_res;

  logic                          accept;
  logic                          stall;
  logic                          s1_go;
  logic                          is_wr;
  logic                          wr_ok;
  logic [6:0]                    row_sel;
  logic [6:0]                    row;
  logic [6:0]                    col_raw;
  logic [6:0]                    col;
  logic [drqe_pkg::TableAw-1:0]  tbl_addr;
  logic                          ram_we;
  logic                          ram_re;
  logic [drqe_pkg::RankW-1:0]    ram_rdata;

  // config port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == drqe_pkg::CfgAddrMarker) ?
                      {{(drqe_pkg::CfgDw-7){1'b0}}, marker_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marker_r <= drqe_pkg::MarkerReset;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr == drqe_pkg::CfgAddrMarker) begin
      marker_r <= cfg_pwdata[6:0];
    end
  end

  // handshake
  assign stall    = out_valid_r && !out_ready;
  assign s1_go    = s1_valid_r && !stall;
  assign in_ready = !s1_valid_r || !stall;
  assign accept   = in_valid && in_ready;

  // table address: row * 95 + column, shared by reads and writes
  assign is_wr   = (in_data.opcode == drqe_pkg::OP_TABLE);
  assign row_sel = is_wr ? in_data.dom_index : cur_class_r;
  assign row     = (int'(row_sel) >= drqe_pkg::MaxClasses) ?
                   7'(drqe_pkg::MaxClasses - 1) : row_sel;
  assign col_raw = in_data.quality - drqe_pkg::FirstQual;
  assign wr_ok   = (int'(in_data.dom_index) < drqe_pkg::MaxClasses) &&
                   (in_data.quality >= drqe_pkg::FirstQual) &&
                   (int'(col_raw) < drqe_pkg::QualSymbols);

  always_comb begin
    if (is_wr) begin
      col = col_raw;
    end else if (in_data.quality < drqe_pkg::FirstQual) begin
      col = '0;
    end else if (int'(col_raw) >= drqe_pkg::QualSymbols) begin
      col = 7'(drqe_pkg::QualSymbols - 1);
    end else begin
      col = col_raw;
    end
  end

  assign tbl_addr = drqe_pkg::TableAw'(row) * drqe_pkg::TableAw'(drqe_pkg::QualSymbols)
                    + drqe_pkg::TableAw'(col);
  assign ram_we   = accept && is_wr && wr_ok;
  assign ram_re   = accept && in_data.opcode == drqe_pkg::OP_QUAL && !cur_div_r;

  drqe_ram #(
    .Width (drqe_pkg::RankW),
    .Depth (drqe_pkg::TableDepth)
  ) u_rank_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tbl_addr),
    .wdata (in_data.rank_value),
    .re    (ram_re),
    .raddr (tbl_addr),
    .rdata (ram_rdata)
  );

  // second stage: rank is back from the ram, run counter update
  always_comb begin
    res         = '0;
    has_res     = 1'b0;
    run_cnt_nxt = run_cnt_r;
    case (s1_kind_r)
      K_TAG: begin
        has_res       = 1'b1;
        res.tag_valid = 1'b1;
        res.line_tag  = s1_tag_r;
      end
      K_DIV: begin
        has_res           = 1'b1;
        res.diverse_valid = 1'b1;
        res.diverse_byte  = s1_byte_r;
      end
      K_FLUSH: begin
        if (run_cnt_r != 8'd0) begin
          has_res          = 1'b1;
          res.run_valid    = 1'b1;
          res.run_byte     = run_cnt_r;
          res.marker_valid = 1'b1;
          run_cnt_nxt      = 8'd0;
        end
      end
      K_RANK: begin
        if (ram_rdata == '0) begin
          if (run_cnt_r >= drqe_pkg::RunLimit) begin
            has_res       = 1'b1;
            res.run_valid = 1'b1;
            res.run_byte  = drqe_pkg::RunCont;
            run_cnt_nxt   = 8'd1;
          end else begin
            run_cnt_nxt = run_cnt_r + 8'd1;
          end
        end else begin
          has_res          = 1'b1;
          res.symbol_valid = 1'b1;
          res.symbol       = ram_rdata;
          if (run_cnt_r != 8'd0) begin
            res.run_valid = 1'b1;
            res.run_byte  = run_cnt_r;
            run_cnt_nxt   = 8'd0;
          end else begin
            res.marker_valid = 1'b1;
          end
        end
      end
      default: begin
        has_res = 1'b0;
      end
    endcase
  end

  // line state and first stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_class_r <= '0;
      cur_div_r   <= 1'b0;
      s1_valid_r  <= 1'b0;
    end else begin
      if (accept && in_data.opcode == drqe_pkg::OP_LINE) begin
        cur_class_r <= in_data.dom_index;
        cur_div_r   <= in_data.diverse_line;
      end
      if (accept && !is_wr) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte_r <= in_data.quality;
      s1_tag_r  <= in_data.diverse_line ? drqe_pkg::DiverseTag : {1'b0, in_data.dom_index};
      case (in_data.opcode)
        drqe_pkg::OP_LINE:  s1_kind_r <= K_TAG;
        drqe_pkg::OP_FLUSH: s1_kind_r <= K_FLUSH;
        default:            s1_kind_r <= cur_div_r ? K_DIV : K_RANK;
      endcase
    end
  end

  // run counter and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_go) begin
        run_cnt_r <= run_cnt_nxt;
      end
      if (s1_go && has_res) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && has_res) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `ASSERT_CLK(a_run_cnt_range, run_cnt_r <= drqe_pkg::RunLimit, "run counter above limit")
  `ASSERT_CLK(a_ready_only_on_stall, !in_ready |-> (s1_valid_r && out_valid_r),
              "input stalled without a held result")
  `ASSERT_CLK(a_run_byte_nonzero, (out_valid_r && out_r.run_valid) |-> (out_r.run_byte != 8'd0),
              "empty run byte emitted")
  `ASSERT_CLK(a_symbol_prefix,
              (out_valid_r && out_r.symbol_valid) |->
                $onehot({out_r.run_valid, out_r.marker_valid}),
              "symbol without exactly one of run byte or marker")

endmodule

[verif/dominant_run_quality_encoder_checker.sv]
// checker for the dominant run quality encoder: predicts every result beat from the
// accepted input beats and compares them field by field, also checks register readback
// depends on drqe_pkg
module dominant_run_quality_encoder_checker
  import drqe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  in_beat_t          in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  out_beat_t         out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CfgAw-1:0]  cfg_paddr,
  input  logic [CfgDw-1:0]  cfg_pwdata,
  input  logic [CfgDw-1:0]  cfg_prdata,
  input  logic              cfg_pready,
  output int                mismatches,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0] run_len;
  logic [6:0] line_class;
  logic       line_diverse;
  logic [6:0] marker_reg;
  logic [6:0] rank_mem [TableDepth];
  out_beat_t  expected_beats [$];

  task automatic encode_beat(input in_beat_t b, output bit emits, output out_beat_t r);
    int         col;
    int         row;
    logic [6:0] rank;
    r = '0;
    emits = 1'b0;
    case (b.opcode)
      OP_TABLE: begin
        col = int'(b.quality) - int'(FirstQual);
        if (int'(b.dom_index) < MaxClasses && col >= 0 && col < QualSymbols)
          rank_mem[int'(b.dom_index) * QualSymbols + col] = b.rank_value;
      end
      OP_LINE: begin
        line_class = b.dom_index;
        line_diverse = b.diverse_line;
        r.tag_valid = 1'b1;
        r.line_tag = b.diverse_line ? DiverseTag : {1'b0, b.dom_index};
        emits = 1'b1;
      end
      OP_FLUSH: begin
        if (run_len != 0) begin
          r.run_valid = 1'b1;
          r.run_byte = run_len;
          r.marker_valid = 1'b1;
          run_len = '0;
          emits = 1'b1;
        end
      end
      default: begin
        emits = 1'b1;
        if (line_diverse) begin
          r.diverse_valid = 1'b1;
          r.diverse_byte = b.quality;
        end else begin
          // out of range bytes clamp to the nearest column
          col = int'(b.quality) - int'(FirstQual);
          if (col < 0) col = 0;
          if (col >= QualSymbols) col = QualSymbols - 1;
          row = int'(line_class);
          if (row >= MaxClasses) row = MaxClasses - 1;
          rank = rank_mem[row * QualSymbols + col];
          if (rank == 0) begin
            if (run_len >= RunLimit) begin
              r.run_valid = 1'b1;
              r.run_byte = RunCont;
              run_len = 8'd1;
            end else begin
              run_len = run_len + 8'd1;
              emits = 1'b0;
            end
          end else begin
            if (run_len != 0) begin
              r.run_valid = 1'b1;
              r.run_byte = run_len;
              run_len = '0;
            end else begin
              r.marker_valid = 1'b1;
            end
            r.symbol_valid = 1'b1;
            r.symbol = rank;
          end
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    out_beat_t want;
    out_beat_t pred;
    bit        emits;
    if (!rst_n) begin
      run_len = '0;
      line_class = '0;
      line_diverse = 1'b0;
      marker_reg = MarkerReset;
      expected_beats.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          $error("result beat with nothing expected");
          mismatches++;
        end else begin
          want = expected_beats.pop_front();
          check_field("run_valid", 8'(want.run_valid), 8'(out_data.run_valid));
          check_field("run_byte", want.run_byte, out_data.run_byte);
          check_field("marker_valid", 8'(want.marker_valid), 8'(out_data.marker_valid));
          check_field("symbol_valid", 8'(want.symbol_valid), 8'(out_data.symbol_valid));
          check_field("symbol", 8'(want.symbol), 8'(out_data.symbol));
          check_field("tag_valid", 8'(want.tag_valid), 8'(out_data.tag_valid));
          check_field("line_tag", want.line_tag, out_data.line_tag);
          check_field("diverse_valid", 8'(want.diverse_valid), 8'(out_data.diverse_valid));
          check_field("diverse_byte", 8'(want.diverse_byte), 8'(out_data.diverse_byte));
        end
      end
      if (in_valid && in_ready) begin
        encode_beat(in_data, emits, pred);
        if (emits) expected_beats.push_back(pred);
      end
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr == CfgAddrMarker) begin
        if (cfg_pwrite) begin
          marker_reg = cfg_pwdata[6:0];
        end else if (cfg_prdata !== CfgDw'(marker_reg)) begin
          $error("no_dom_marker readback: expected %0d, got %0d", marker_reg, cfg_prdata);
          mismatches++;
        end
      end
    end
    pending = expected_beats.size();
  end

endmodule

[verif/dominant_run_quality_encoder_test.sv]
// top of the dominant run quality encoder test: clock, reset, stimulus and verdict
// depends on drqe_pkg, dominant_run_quality_encoder and dominant_run_quality_encoder_checker
module dominant_run_quality_encoder_test;
  import drqe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QualBase = int'(FirstQual);
  localparam int InBeatW  = $bits(in_beat_t);

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  in_beat_t         in_data;
  logic             out_valid;
  logic             out_ready;
  out_beat_t        out_data;
  logic             cfg_psel;
  logic             cfg_penable;
  logic             cfg_pwrite;
  logic [CfgAw-1:0] cfg_paddr;
  logic [CfgDw-1:0] cfg_pwdata;
  logic [CfgDw-1:0] cfg_prdata;
  logic             cfg_pready;

  int mismatch_count;
  int pending_results;
  int send_idle = 0;
  int recv_idle = 0;
  bit hold_req = 1'b0;
  int beats_sent = 0;

  // stimulus side view of the rank table, used to steer long runs
  logic [6:0]            rank_shadow [TableDepth];
  bit [MaxClasses-1:0]   class_ready = '0;
  int                    ready_classes [$];

  always #5ns clk = ~clk;

  dominant_run_quality_encoder uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  dominant_run_quality_encoder_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .mismatches  (mismatch_count),
    .pending     (pending_results)
  );

  // unused fields of a beat carry random bits
  function automatic in_beat_t noise_beat();
    logic [InBeatW-1:0] raw;
    raw = InBeatW'($urandom);
    return in_beat_t'(raw);
  endfunction

  task automatic push(input in_beat_t b);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    beats_sent++;
  endtask

  task automatic put_table(input int dom, input int q, input int rank);
    in_beat_t b;
    b = noise_beat();
    b.opcode = OP_TABLE;
    b.dom_index = 7'(dom);
    b.quality = 7'(q);
    b.rank_value = 7'(rank);
    if (q >= QualBase && q - QualBase < QualSymbols)
      rank_shadow[dom * QualSymbols + q - QualBase] = 7'(rank);
    push(b);
  endtask

  task automatic put_line(input int dom, input bit diverse);
    in_beat_t b;
    b = noise_beat();
    b.opcode = OP_LINE;
    b.dom_index = 7'(dom);
    b.diverse_line = diverse;
    push(b);
  endtask

  task automatic put_qual(input int q);
    in_beat_t b;
    b = noise_beat();
    b.opcode = OP_QUAL;
    b.quality = 7'(q);
    push(b);
  endtask

  task automatic put_flush();
    in_beat_t b;
    b = noise_beat();
    b.opcode = OP_FLUSH;
    push(b);
  endtask

  // a ranked line only ever reads classes whose whole row has been written
  task automatic ranked_line(input bit long_run);
    int c;
    int zc;
    if (ready_classes.size() == 0 || (ready_classes.size() < 8 && $urandom_range(7) == 0)) begin
      c = $urandom_range(MaxClasses - 1);
      if (!class_ready[c]) begin
        for (int col = 0; col < QualSymbols; col++)
          put_table(c, QualBase + col,
                    (col == c % QualSymbols || $urandom_range(99) < 60) ? 0
                                                                       : $urandom_range(127, 1));
        class_ready[c] = 1'b1;
        ready_classes.push_back(c);
      end
    end else begin
      c = ready_classes[$urandom_range(ready_classes.size() - 1)];
    end
    put_line(c, 1'b0);
    zc = -1;
    for (int col = 0; col < QualSymbols && zc < 0; col++)
      if (rank_shadow[c * QualSymbols + col] == 7'd0) zc = col;
    // long stretch of dominant bytes pushes the run past its limit
    if ((long_run || $urandom_range(14) == 0) && zc >= 0)
      repeat ($urandom_range(600, 260)) put_qual(QualBase + zc);
    else
      repeat ($urandom_range(40, 1)) put_qual($urandom_range(127));
  endtask

  task automatic cfg_access(input bit wr, input logic [6:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= CfgAddrMarker;
    cfg_pwdata <= CfgDw'(value);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  // silent beats may still be in flight once the last result is out
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  initial begin : receiver
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  initial begin : watchdog
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    int budget_end;
    int pick;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    cfg_access(1'b0, 7'd0);

    put_flush();
    put_table(127, 32, 0);
    put_table(127, 126, 127);
    put_table(0, 33, 1);
    put_table(0, 80, 0);
    put_table(5, 31, 9);
    put_table(5, 127, 9);
    put_line(127, 1'b0);
    put_qual(0);
    put_qual(127);
    put_qual(126);
    put_line(0, 1'b1);
    put_qual(0);
    put_qual(127);
    put_qual(64);
    put_line(0, 1'b0);
    put_qual(33);
    put_qual(80);
    put_line(127, 1'b0);
    put_qual(32);
    put_flush();
    put_flush();
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      cfg_access(1'b1, phase == 0 ? 7'd127 : phase == 1 ? 7'd0 : 7'($urandom_range(126, 1)));
      cfg_access(1'b0, 7'd0);
      send_idle = phase == 0 ? 19 : phase == 1 ? 80 : 0;
      recv_idle = phase == 0 ? 80 : phase == 1 ? 19 : 0;
      if (phase == 2) hold_req = 1'b1;
      budget_end = beats_sent + 650;
      ranked_line(1'b1);
      while (beats_sent < budget_end) begin
        pick = $urandom_range(99);
        if (pick < 6) begin
          put_table($urandom_range(127), $urandom_range(127), $urandom_range(127));
        end else if (pick < 10) begin
          put_flush();
        end else if (pick < 30) begin
          put_line($urandom_range(127), 1'b1);
          repeat ($urandom_range(30, 1)) put_qual($urandom_range(127));
        end else begin
          ranked_line(1'b0);
        end
      end
      drain();
    end

    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
